>>> hw/rtl/g2l_pkg.sv
// Shared types, constants and lookup tables for the Gregorian to lunar date converter.
package g2l_pkg;

	localparam int TABLE_YEARS    = 150;
	localparam int BASE_YEAR      = 1900;
	localparam int ROM_YEARS      = 150;
	localparam int YEAR_LIMIT     = (TABLE_YEARS < ROM_YEARS) ? TABLE_YEARS : ROM_YEARS;
	localparam int NEWYEAR_OFFSET = 30;
	localparam int DAYS_PER_YEAR  = 365;
	localparam int LUNAR_BASE_LEN = 348;
	localparam int ZOD_RECIP      = 2731;
	localparam int ZOD_SHIFT      = 15;

	localparam logic [7:0] YEAR_LAST = 8'(YEAR_LIMIT - 1);

	localparam logic [16:0] YEAR_ROM [ROM_YEARS] = '{
		17'h04bd8, 17'h04ae0, 17'h0a570, 17'h054d5, 17'h0d260,
		17'h0d950, 17'h16554, 17'h056a0, 17'h09ad0, 17'h055d2,
		17'h04ae0, 17'h0a5b6, 17'h0a4d0, 17'h0d250, 17'h1d255,
		17'h0b540, 17'h0d6a0, 17'h0ada2, 17'h095b0, 17'h14977,
		17'h04970, 17'h0a4b0, 17'h0b4b5, 17'h06a50, 17'h06d40,
		17'h1ab54, 17'h02b60, 17'h09570, 17'h052f2, 17'h04970,
		17'h06566, 17'h0d4a0, 17'h0ea50, 17'h06e95, 17'h05ad0,
		17'h02b60, 17'h186e3, 17'h092e0, 17'h1c8d7, 17'h0c950,
		17'h0d4a0, 17'h1d8a6, 17'h0b550, 17'h056a0, 17'h1a5b4,
		17'h025d0, 17'h092d0, 17'h0d2b2, 17'h0a950, 17'h0b557,
		17'h06ca0, 17'h0b550, 17'h15355, 17'h04da0, 17'h0a5d0,
		17'h14573, 17'h052d0, 17'h0a9a8, 17'h0e950, 17'h06aa0,
		17'h0aea6, 17'h0ab50, 17'h04b60, 17'h0aae4, 17'h0a570,
		17'h05260, 17'h0f263, 17'h0d950, 17'h05b57, 17'h056a0,
		17'h096d0, 17'h04dd5, 17'h04ad0, 17'h0a4d0, 17'h0d4d4,
		17'h0d250, 17'h0d558, 17'h0b540, 17'h0b5a0, 17'h195a6,
		17'h095b0, 17'h049b0, 17'h0a974, 17'h0a4b0, 17'h0b27a,
		17'h06a50, 17'h06d40, 17'h0af46, 17'h0ab60, 17'h09570,
		17'h04af5, 17'h04970, 17'h064b0, 17'h074a3, 17'h0ea50,
		17'h06b58, 17'h055c0, 17'h0ab60, 17'h096d5, 17'h092e0,
		17'h0c960, 17'h0d954, 17'h0d4a0, 17'h0da50, 17'h07552,
		17'h056a0, 17'h0abb7, 17'h025d0, 17'h092d0, 17'h0cab5,
		17'h0a950, 17'h0b4a0, 17'h0baa4, 17'h0ad50, 17'h055d9,
		17'h04ba0, 17'h0a5b0, 17'h15176, 17'h052b0, 17'h0a930,
		17'h07954, 17'h06aa0, 17'h0ad50, 17'h05b52, 17'h04b60,
		17'h0a6e6, 17'h0a4e0, 17'h0d260, 17'h0ea65, 17'h0d530,
		17'h05aa0, 17'h076a3, 17'h096d0, 17'h04afb, 17'h04ad0,
		17'h0a4d0, 17'h1d0b6, 17'h0d250, 17'h0d520, 17'h0dd45,
		17'h0b5a0, 17'h056d0, 17'h055b2, 17'h049b0, 17'h0a577,
		17'h0a4b0, 17'h0aa50, 17'h1b255, 17'h06d20, 17'h0ada0
	};

	localparam logic [8:0] MONTH_START [12] = '{
		9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
		9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
	};

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_CALC,
		OP_SUM,
		OP_YEAR,
		OP_MONTH,
		OP_LEAP,
		OP_FIN,
		OP_ZMUL,
		OP_ZMOD,
		OP_OUT
	} g2l_op_t;

	typedef struct packed {
		g2l_op_t op;
		logic    res_ok;
		logic    res_leap;
	} g2l_cmd_t;

	typedef struct packed {
		logic range_ok;
		logic days_neg;
		logic days_big;
		logic year_hit;
		logic year_last;
		logic month_hit;
		logic at_leap;
		logic month_last;
		logic leap_hit;
	} g2l_stat_t;

	function automatic logic [16:0] rom_word(input logic [7:0] idx);
		logic [16:0] w;
		w = '0;
		if (int'(idx) < ROM_YEARS) begin
			w = YEAR_ROM[idx];
		end
		return w;
	endfunction

	function automatic logic [8:0] month_start(input logic [3:0] m);
		logic [8:0] s;
		logic [3:0] k;
		s = '0;
		k = m - 4'd1;
		if (m >= 4'd1 && m <= 4'd12) begin
			s = MONTH_START[k];
		end
		return s;
	endfunction

	function automatic logic [4:0] leap_len(input logic [16:0] w);
		logic [4:0] l;
		if (w[3:0] == 4'd0) begin
			l = 5'd0;
		end else if (w[16]) begin
			l = 5'd30;
		end else begin
			l = 5'd29;
		end
		return l;
	endfunction

	function automatic logic [4:0] month_len(input logic [16:0] w, input logic [3:0] m);
		logic [4:0] idx;
		idx = 5'd16 - {1'b0, m};
		return w[idx] ? 5'd30 : 5'd29;
	endfunction

	function automatic logic [8:0] year_len(input logic [16:0] w);
		logic [8:0] sum;
		sum = 9'(LUNAR_BASE_LEN);
		for (int b = 4; b < 16; b++) begin
			sum = sum + {8'd0, w[b]};
		end
		return sum + {4'd0, leap_len(w)};
	endfunction

endpackage

>>> hw/rtl/g2l_ctrl.sv
// Controller state machine that sequences one date conversion through the datapath.
module g2l_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	input  g2l_pkg::g2l_stat_t stat,
	output g2l_pkg::g2l_cmd_t  cmd
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CALC,
		ST_SUM,
		ST_CHK,
		ST_YEAR,
		ST_MONTH,
		ST_LEAP,
		ST_FIN,
		ST_ZMUL,
		ST_ZMOD,
		ST_OUT
	} state_t;

	state_t state_q;
	logic   fail_q;
	logic   leap_q;
	logic   out_valid_q;
	logic   out_load;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_load  = (state_q == ST_OUT) && (!out_valid_q || out_ready);

	always_comb begin
		cmd.op       = g2l_pkg::OP_NONE;
		cmd.res_ok   = !fail_q && !stat.days_big;
		cmd.res_leap = leap_q;
		case (state_q)
			ST_IDLE:  cmd.op = in_valid ? g2l_pkg::OP_LOAD : g2l_pkg::OP_NONE;
			ST_CALC:  cmd.op = g2l_pkg::OP_CALC;
			ST_SUM:   cmd.op = g2l_pkg::OP_SUM;
			ST_YEAR:  cmd.op = g2l_pkg::OP_YEAR;
			ST_MONTH: cmd.op = g2l_pkg::OP_MONTH;
			ST_LEAP:  cmd.op = g2l_pkg::OP_LEAP;
			ST_FIN:   cmd.op = g2l_pkg::OP_FIN;
			ST_ZMUL:  cmd.op = g2l_pkg::OP_ZMUL;
			ST_ZMOD:  cmd.op = g2l_pkg::OP_ZMOD;
			ST_OUT:   cmd.op = out_load ? g2l_pkg::OP_OUT : g2l_pkg::OP_NONE;
			default:  cmd.op = g2l_pkg::OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fail_q      <= 1'b0;
			leap_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						fail_q  <= 1'b0;
						leap_q  <= 1'b0;
						state_q <= ST_CALC;
					end
				end
				ST_CALC: state_q <= ST_SUM;
				ST_SUM:  state_q <= ST_CHK;
				ST_CHK: begin
					if (!stat.range_ok || stat.days_neg) begin
						fail_q  <= 1'b1;
						state_q <= ST_FIN;
					end else begin
						state_q <= ST_YEAR;
					end
				end
				ST_YEAR: begin
					if (stat.year_hit) begin
						state_q <= ST_MONTH;
					end else if (stat.year_last) begin
						fail_q  <= 1'b1;
						state_q <= ST_FIN;
					end
				end
				ST_MONTH: begin
					if (stat.month_hit || (!stat.at_leap && stat.month_last)) begin
						state_q <= ST_FIN;
					end else if (stat.at_leap) begin
						state_q <= ST_LEAP;
					end
				end
				ST_LEAP: begin
					if (stat.leap_hit) begin
						leap_q  <= 1'b1;
						state_q <= ST_FIN;
					end else if (stat.month_last) begin
						state_q <= ST_FIN;
					end else begin
						state_q <= ST_MONTH;
					end
				end
				ST_FIN:  state_q <= ST_ZMUL;
				ST_ZMUL: state_q <= ST_ZMOD;
				ST_ZMOD: state_q <= ST_OUT;
				ST_OUT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

>>> hw/rtl/g2l_dp.sv
// Datapath: day count, lunar year and month walk over the table, zodiac and output register.
module g2l_dp (
	input  logic               clk,
	input  g2l_pkg::g2l_cmd_t  cmd,
	input  logic [11:0]        greg_year,
	input  logic [3:0]         greg_month,
	input  logic [4:0]         greg_day,
	output g2l_pkg::g2l_stat_t stat,
	output logic               in_range,
	output logic [11:0]        lunar_year_out,
	output logic [3:0]         lunar_month_out,
	output logic [4:0]         lunar_day_out,
	output logic               leap_flag,
	output logic [3:0]         zodiac_index
);

	logic [11:0]        year_q;
	logic [3:0]         month_q;
	logic [4:0]         day_q;
	logic [16:0]        t1_q;
	logic [9:0]         t2_q;
	logic signed [16:0] days_q;
	logic [7:0]         idx_q;
	logic [3:0]         mon_q;

	logic        res_ok_q;
	logic [11:0] res_year_q;
	logic [3:0]  res_month_q;
	logic [4:0]  res_day_q;
	logic        res_leap_q;
	logic [24:0] zprod_q;
	logic [3:0]  res_zod_q;

	logic        out_ok_q;
	logic [11:0] out_year_q;
	logic [3:0]  out_month_q;
	logic [4:0]  out_day_q;
	logic        out_leap_q;
	logic [3:0]  out_zod_q;

	logic [11:0] offset;
	logic [7:0]  off8;
	logic [8:0]  leaps;
	logic        greg_leap;
	logic [16:0] word;
	logic [8:0]  ylen;
	logic [4:0]  mlen;
	logic [4:0]  llen;
	logic [12:0] zx;
	logic [9:0]  zq;
	logic [12:0] zrem;

	assign offset = year_q - 12'(g2l_pkg::BASE_YEAR);
	assign off8   = offset[7:0];
	// Leap years in [BASE_YEAR, year-1]: every fourth year, but not the base year itself.
	assign leaps     = ((9'(off8) + 9'd3) >> 2) - {8'd0, (off8 != 8'd0)};
	assign greg_leap = (off8[1:0] == 2'd0) && (off8 != 8'd0) && (month_q > 4'd2);

	assign word = g2l_pkg::rom_word(idx_q);
	assign ylen = g2l_pkg::year_len(word);
	assign mlen = g2l_pkg::month_len(word, mon_q);
	assign llen = g2l_pkg::leap_len(word);

	assign zx   = {1'b0, res_year_q} + 13'd8;
	assign zq   = zprod_q[24:g2l_pkg::ZOD_SHIFT];
	assign zrem = zx - (13'(zq) << 3) - (13'(zq) << 2);

	always_comb begin
		stat.range_ok   = (year_q >= 12'(g2l_pkg::BASE_YEAR))
		               && (year_q < 12'(g2l_pkg::BASE_YEAR + g2l_pkg::YEAR_LIMIT))
		               && (month_q >= 4'd1) && (month_q <= 4'd12);
		stat.days_neg   = days_q[16];
		stat.days_big   = days_q[16] || (days_q[15:0] > 16'd29);
		stat.year_hit   = days_q[15:0] < 16'(ylen);
		stat.year_last  = (idx_q == g2l_pkg::YEAR_LAST);
		stat.month_hit  = days_q[15:0] < 16'(mlen);
		stat.at_leap    = (mon_q == word[3:0]);
		stat.month_last = (mon_q == 4'd12);
		stat.leap_hit   = days_q[15:0] < 16'(llen);
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			g2l_pkg::OP_LOAD: begin
				year_q  <= greg_year;
				month_q <= greg_month;
				day_q   <= greg_day;
			end
			g2l_pkg::OP_CALC: begin
				t1_q <= 17'(off8) * 17'(g2l_pkg::DAYS_PER_YEAR) + 17'(leaps);
				t2_q <= 10'(g2l_pkg::month_start(month_q)) + 10'(day_q)
				      + 10'(greg_leap) - 10'(g2l_pkg::NEWYEAR_OFFSET + 1);
			end
			g2l_pkg::OP_SUM: begin
				days_q <= $signed(t1_q) + $signed({{7{t2_q[9]}}, t2_q});
				idx_q  <= 8'd0;
			end
			g2l_pkg::OP_YEAR: begin
				if (stat.year_hit) begin
					mon_q <= 4'd1;
				end else begin
					days_q <= days_q - $signed(17'(ylen));
					idx_q  <= idx_q + 8'd1;
				end
			end
			g2l_pkg::OP_MONTH: begin
				if (!stat.month_hit) begin
					days_q <= days_q - $signed(17'(mlen));
					if (!stat.at_leap && !stat.month_last) begin
						mon_q <= mon_q + 4'd1;
					end
				end
			end
			g2l_pkg::OP_LEAP: begin
				if (!stat.leap_hit) begin
					days_q <= days_q - $signed(17'(llen));
					if (!stat.month_last) begin
						mon_q <= mon_q + 4'd1;
					end
				end
			end
			g2l_pkg::OP_FIN: begin
				res_ok_q <= cmd.res_ok;
				if (cmd.res_ok) begin
					res_year_q  <= 12'(g2l_pkg::BASE_YEAR) + {4'd0, idx_q};
					res_month_q <= mon_q;
					res_day_q   <= days_q[4:0] + 5'd1;
					res_leap_q  <= cmd.res_leap;
				end else begin
					res_year_q  <= year_q;
					res_month_q <= 4'd1;
					res_day_q   <= day_q;
					res_leap_q  <= 1'b0;
				end
			end
			g2l_pkg::OP_ZMUL: begin
				// Reciprocal of twelve, exact for every 13-bit value used here.
				zprod_q <= 25'(zx) * 25'(g2l_pkg::ZOD_RECIP);
			end
			g2l_pkg::OP_ZMOD: begin
				res_zod_q <= zrem[3:0];
			end
			g2l_pkg::OP_OUT: begin
				out_ok_q    <= res_ok_q;
				out_year_q  <= res_year_q;
				out_month_q <= res_month_q;
				out_day_q   <= res_day_q;
				out_leap_q  <= res_leap_q;
				out_zod_q   <= res_zod_q;
			end
			default: begin
			end
		endcase
	end

	assign in_range        = out_ok_q;
	assign lunar_year_out  = out_year_q;
	assign lunar_month_out = out_month_q;
	assign lunar_day_out   = out_day_q;
	assign leap_flag       = out_leap_q;
	assign zodiac_index    = out_zod_q;

endmodule

>>> hw/rtl/gregorian_to_lunar_date.sv
// Top level of the Gregorian to Chinese lunar date converter.
// Converts one Gregorian date per item into the lunar year, month, day, leap-month flag and
// zodiac sign, counting days from the lunar new year of 1900 and walking a table of 150
// lunar years. Dates outside the table come back with year and day unchanged, month 1 and
// tuser low. The block works on one item at a time: after acceptance it forms the day count,
// checks the range, walks the table years and then the months of the found year, and
// computes the zodiac sign before the result is loaded; dates rejected by the range check
// skip the walk. The result sits in an output register, so the next item is accepted in
// the cycle after the result has been loaded there; a finished result waits until the
// previous one has been taken by the receiver.
module gregorian_to_lunar_date (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [11:0] greg_year, [15:12] greg_month, [20:16] greg_day, [23:21] zero
	input  logic [23:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [11:0] lunar_year_out, [15:12] lunar_month_out, [20:16] lunar_day_out,
	// [21] leap_flag, [25:22] zodiac_index, [31:26] zero
	output logic [31:0] m_axis_tdata,
	// [0] in_range
	output logic [0:0]  m_axis_tuser
);

	g2l_pkg::g2l_cmd_t  cmd;
	g2l_pkg::g2l_stat_t stat;

	logic        in_range;
	logic [11:0] lunar_year_out;
	logic [3:0]  lunar_month_out;
	logic [4:0]  lunar_day_out;
	logic        leap_flag;
	logic [3:0]  zodiac_index;

	g2l_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.stat      (stat),
		.cmd       (cmd)
	);

	g2l_dp u_dp (
		.clk             (clk),
		.cmd             (cmd),
		.greg_year       (s_axis_tdata[11:0]),
		.greg_month      (s_axis_tdata[15:12]),
		.greg_day        (s_axis_tdata[20:16]),
		.stat            (stat),
		.in_range        (in_range),
		.lunar_year_out  (lunar_year_out),
		.lunar_month_out (lunar_month_out),
		.lunar_day_out   (lunar_day_out),
		.leap_flag       (leap_flag),
		.zodiac_index    (zodiac_index)
	);

	assign m_axis_tdata = {6'd0, zodiac_index, leap_flag, lunar_day_out,
	                       lunar_month_out, lunar_year_out};
	assign m_axis_tuser = in_range;

endmodule
